FILE: src/dfq_pkg.sv
package dfq_pkg;

    typedef enum logic [1:0] {
        MODE_Q32_32 = 2'd0,
        MODE_Q48_16 = 2'd1,
        MODE_Q56_8  = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
    localparam int unsigned EXP_BIAS_PLUS_MANT = 1075;
    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        neg;
        logic        nan;
        logic        ovf;
        logic        left;
        logic        zero;
        logic [52:0] mant;
        logic [5:0]  amount;
    } decode_t;

    function automatic logic [6:0] frac_bits(input logic [1:0] mode);
        logic [6:0] r;
        begin
            unique case (mode_t'(mode))
                MODE_Q32_32: r = 7'd32;
                MODE_Q48_16: r = 7'd16;
                MODE_Q56_8:  r = 7'd8;
                MODE_SPARE:  r = 7'd8;
                default:     r = 7'd8;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: src/double_to_fixed_quantizer.sv
// Double to signed 64-bit fixed-point converter.
// A request is taken at a rising edge where start is high and busy is low;
// busy is always low, so one request may be issued in every cycle.
// value_bits carries a raw binary64 pattern and mode selects Q32.32, Q48.16
// or Q56.8 (the spare code behaves as Q56.8).
// The request is registered in the input register, decoded and aligned in one
// pass of logic, and the result is held in the result register, marked by done for
// exactly one cycle. Throughput is one result per cycle.
// fixed_value is rounded to nearest, ties to even. Results beyond the signed
// 64-bit range saturate and raise overflow; a NaN gives zero and raises
// not_a_number.
// The receiver cannot stall: each result must be taken in the cycle that it
// is shown. Reset clears the valid flags, so no result is shown after reset
// until a new request has been taken.
module double_to_fixed_quantizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] value_bits,
    input  logic [1:0]  mode,
    output logic        done,
    output logic signed [63:0] fixed_value,
    output logic        overflow,
    output logic        not_a_number
);

    logic        in_valid_reg;
    logic [63:0] bits_reg;
    logic [1:0]  mode_reg;
    logic        out_valid_reg;
    logic [63:0] fixed_reg;
    logic        ovf_reg;
    logic        nan_reg;
    dfq_pkg::decode_t dec;
    logic [63:0] fixed_next;
    logic        ovf_next;
    logic        nan_next;

    assign busy = 1'b0;

    dfq_decode u_decode (
        .value_bits(bits_reg),
        .mode(mode_reg),
        .dec(dec)
    );

    dfq_align u_align (
        .dec(dec),
        .fixed_value(fixed_next),
        .overflow(ovf_next),
        .not_a_number(nan_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            bits_reg <= value_bits;
            mode_reg <= mode;
        end
        if (in_valid_reg)
        begin
            fixed_reg <= fixed_next;
            ovf_reg <= ovf_next;
            nan_reg <= nan_next;
        end
    end

    assign done = out_valid_reg;
    assign fixed_value = fixed_reg;
    assign overflow = ovf_reg;
    assign not_a_number = nan_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done) else $error("result not delivered");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2)) else $error("result without request");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(overflow && not_a_number)) else $error("both flags set");
    a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && not_a_number) |-> (fixed_value == 64'sd0))
        else $error("NaN result not zero");

endmodule

FILE: src/dfq_decode.sv
module dfq_decode (
    input  logic [63:0]           value_bits,
    input  logic [1:0]            mode,
    output dfq_pkg::decode_t      dec
);

    logic [10:0] exp_f;
    logic [51:0] frac_f;
    logic [52:0] m;
    logic signed [13:0] e;

    always_comb
    begin
        exp_f = value_bits[62:52];
        frac_f = value_bits[51:0];
        m = (exp_f != 11'd0) ? {1'b1, frac_f} : {1'b0, frac_f};
        e = $signed({3'b000, (exp_f != 11'd0) ? exp_f : 11'd1})
            - $signed(14'(dfq_pkg::EXP_BIAS_PLUS_MANT))
            + $signed({7'd0, dfq_pkg::frac_bits(mode)});
        dec = '0;
        dec.neg = value_bits[63];
        dec.mant = m;
        if (exp_f == dfq_pkg::EXP_ALL_ONES)
        begin
            dec.nan = (frac_f != 52'd0);
            dec.ovf = (frac_f == 52'd0);
        end
        else if (m == 53'd0)
        begin
            dec.zero = 1'b1;
        end
        else if (e > 14'sd63)
        begin
            dec.ovf = 1'b1;
        end
        else if (e >= 14'sd0)
        begin
            dec.left = 1'b1;
            dec.amount = e[5:0];
        end
        else if (e <= -14'sd54)
        begin
            dec.zero = 1'b1;
        end
        else
        begin
            dec.amount = 6'((-e));
        end
    end

endmodule

FILE: src/dfq_align.sv
module dfq_align (
    input  dfq_pkg::decode_t dec,
    output logic [63:0]      fixed_value,
    output logic             overflow,
    output logic             not_a_number
);

    logic [116:0] wide;
    logic [63:0]  q;
    logic [63:0]  rem;
    logic [63:0]  half;
    logic [63:0]  mag;
    logic         ovf;

    always_comb
    begin
        wide = {64'd0, dec.mant} << dec.amount;
        q = {11'd0, dec.mant} >> dec.amount;
        rem = {11'd0, dec.mant} & ((64'd1 << dec.amount) - 64'd1);
        half = (64'd1 << dec.amount) >> 1;
        mag = 64'd0;
        ovf = dec.ovf;
        if (dec.zero || dec.nan || dec.ovf)
        begin
            mag = 64'd0;
        end
        else if (dec.left)
        begin
            if (wide[116:63] != 54'd0)
            begin
                if (dec.neg && wide[116:63] == 54'd1 && wide[62:0] == 63'd0)
                    mag = dfq_pkg::SAT_NEG;
                else
                    ovf = 1'b1;
            end
            else
                mag = wide[63:0];
        end
        else
        begin
            mag = q + {63'd0, (rem > half) || ((rem == half) && q[0])};
        end
        not_a_number = dec.nan;
        overflow = ovf;
        if (dec.nan)
            fixed_value = 64'd0;
        else if (ovf)
            fixed_value = dec.neg ? dfq_pkg::SAT_NEG : dfq_pkg::SAT_POS;
        else
            fixed_value = dec.neg ? (64'd0 - mag) : mag;
    end

endmodule

FILE: dv/double_to_fixed_quantizer_test.sv
module double_to_fixed_quantizer_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] value_bits;
        logic [1:0]  mode;
    } request_t;

    typedef struct {
        logic [63:0] fixed_value;
        logic        overflow;
        logic        not_a_number;
    } fixed_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] value_bits;
    logic [1:0]  mode;
    logic        done;
    logic signed [63:0] fixed_value;
    logic        overflow;
    logic        not_a_number;

    request_t      pending_requests[$];
    fixed_result_t expected_results[$];
    int            failures;
    int            checked;
    int            saturated_seen;
    int            nan_seen;
    int            idle_left;
    bit            idling_allowed;
    bit            stimulus_done;

    double_to_fixed_quantizer dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value_bits(value_bits),
        .mode(mode),
        .done(done),
        .fixed_value(fixed_value),
        .overflow(overflow),
        .not_a_number(not_a_number)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic fixed_result_t quantize(input logic [63:0] bits, input logic [1:0] sel);
        fixed_result_t r;
        logic          neg;
        logic [10:0]   expo;
        logic [51:0]   frac;
        logic [63:0]   m;
        logic [63:0]   mag;
        logic [63:0]   q;
        logic [63:0]   rem;
        logic [63:0]   half;
        int            e;
        int            s;
        logic          ovf;
        neg = bits[63];
        expo = bits[62:52];
        frac = bits[51:0];
        mag = '0;
        ovf = 1'b0;
        r.fixed_value = '0;
        r.overflow = 1'b0;
        r.not_a_number = 1'b0;
        if (expo == dfq_pkg::EXP_ALL_ONES)
        begin
            if (frac != '0)
            begin
                r.not_a_number = 1'b1;
                return r;
            end
            ovf = 1'b1;
        end
        else
        begin
            m = (expo != '0) ? {11'd0, 1'b1, frac} : {12'd0, frac};
            e = ((expo != '0) ? int'(expo) : 1) - 1075;
            case (dfq_pkg::mode_t'(sel))
                dfq_pkg::MODE_Q32_32: e = e + 32;
                dfq_pkg::MODE_Q48_16: e = e + 16;
                default:              e = e + 8;
            endcase
            if (m == '0)
                mag = '0;
            else if (e > 63)
                ovf = 1'b1;
            else if (e >= 0)
            begin
                if ((m >> (63 - e)) != '0)
                begin
                    if (neg && m == (64'd1 << (63 - e)))
                        mag = dfq_pkg::SAT_NEG;
                    else
                        ovf = 1'b1;
                end
                else
                    mag = m << e;
            end
            else
            begin
                s = -e;
                if (s >= 54)
                    mag = '0;
                else
                begin
                    q = m >> s;
                    rem = m & ((64'd1 << s) - 64'd1);
                    half = 64'd1 << (s - 1);
                    if (rem > half || (rem == half && q[0]))
                        q = q + 64'd1;
                    mag = q;
                end
            end
        end
        if (ovf)
        begin
            r.fixed_value = neg ? dfq_pkg::SAT_NEG : dfq_pkg::SAT_POS;
            r.overflow = 1'b1;
        end
        else
            r.fixed_value = neg ? (64'd0 - mag) : mag;
        return r;
    endfunction

    function automatic logic [63:0] make_double(input logic sgn, input int expo,
                                               input logic [51:0] frac);
        return {sgn, expo[10:0], frac};
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (idle_left > 0)
        begin
            idle_left <= idle_left - 1;
            start <= 1'b0;
        end
        else if (start && busy)
            start <= 1'b1;
        else if (pending_requests.size() > 0 && idling_allowed && $urandom_range(0, 15) == 0)
        begin
            idle_left <= $urandom_range(0, 10);
            start <= 1'b0;
        end
        else if (pending_requests.size() > 0)
        begin
            request_t req;
            req = pending_requests.pop_front();
            value_bits <= req.value_bits;
            mode <= req.mode;
            start <= 1'b1;
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            expected_results.push_back(quantize(value_bits, mode));
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected: actual %h ovf %b nan %b",
                         $time, fixed_value, overflow, not_a_number);
                failures++;
            end
            else
            begin
                fixed_result_t exp_r;
                exp_r = expected_results.pop_front();
                checked++;
                if (exp_r.overflow) saturated_seen++;
                if (exp_r.not_a_number) nan_seen++;
                if (fixed_value !== exp_r.fixed_value)
                begin
                    $display("%0t: fixed_value expected %h actual %h",
                             $time, exp_r.fixed_value, fixed_value);
                    failures++;
                end
                if (overflow !== exp_r.overflow)
                begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, exp_r.overflow, overflow);
                    failures++;
                end
                if (not_a_number !== exp_r.not_a_number)
                begin
                    $display("%0t: not_a_number expected %b actual %b",
                             $time, exp_r.not_a_number, not_a_number);
                    failures++;
                end
            end
        end
    end

    function automatic request_t random_request();
        request_t req;
        int       sel;
        int       e;
        req.mode = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 9);
        if (sel < 2)
            req.value_bits = {$urandom, $urandom};
        else
        begin
            // Exponents are mostly kept where rounding and saturation happen.
            if (sel < 7)
                e = $urandom_range(1075 - 40, 1075 + 1);
            else if (sel < 9)
                e = $urandom_range(1075 + 40, 1075 + 60);
            else
                e = $urandom_range(0, 2047);
            req.value_bits = make_double(1'($urandom_range(0, 1)), e,
                                         {20'($urandom_range(0, 1048575)), $urandom});
            if ($urandom_range(0, 3) == 0)
                req.value_bits[20:0] = ($urandom_range(0, 1) != 0) ? 21'h100000 : 21'h0;
        end
        return req;
    endfunction

    task automatic add_request(input logic [63:0] bits, input logic [1:0] sel);
        request_t req;
        req.value_bits = bits;
        req.mode = sel;
        pending_requests.push_back(req);
    endtask

    initial
    begin
        failures = 0;
        checked = 0;
        saturated_seen = 0;
        nan_seen = 0;
        idle_left = 0;
        idling_allowed = 1'b1;
        stimulus_done = 1'b0;
        start = 1'b0;
        value_bits = '0;
        mode = dfq_pkg::MODE_Q32_32;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_request(64'h0, dfq_pkg::MODE_Q32_32);
        add_request(64'h8000_0000_0000_0000, dfq_pkg::MODE_Q48_16);
        add_request(64'h3FF0_0000_0000_0000, dfq_pkg::MODE_Q32_32);
        add_request(64'hBFF8_0000_0000_0000, dfq_pkg::MODE_Q56_8);
        add_request(64'h7FF0_0000_0000_0000, dfq_pkg::MODE_Q48_16);
        add_request(64'hFFF0_0000_0000_0000, dfq_pkg::MODE_Q32_32);
        add_request(64'h7FF8_0000_0000_0000, dfq_pkg::MODE_Q56_8);
        add_request(64'hFFFF_FFFF_FFFF_FFFF, dfq_pkg::MODE_SPARE);
        add_request(64'h7FF0_0000_0000_0001, dfq_pkg::MODE_Q32_32);
        add_request(64'h0000_0000_0000_0001, dfq_pkg::MODE_Q32_32);
        add_request(64'h000F_FFFF_FFFF_FFFF, dfq_pkg::MODE_Q56_8);
        add_request(64'h7FEF_FFFF_FFFF_FFFF, dfq_pkg::MODE_Q48_16);
        add_request(make_double(1'b1, 1023 + 31, 52'h0), dfq_pkg::MODE_Q32_32);
        add_request(make_double(1'b0, 1023 + 31, 52'h0), dfq_pkg::MODE_Q32_32);
        add_request(make_double(1'b1, 1023 + 55, 52'h0), dfq_pkg::MODE_Q56_8);
        add_request(make_double(1'b1, 1023 + 55, 52'h1), dfq_pkg::MODE_SPARE);
        add_request(make_double(1'b0, 1023 - 33, 52'h0), dfq_pkg::MODE_Q32_32);
        add_request(make_double(1'b0, 1023 - 33, 52'h8_0000_0000_0000), dfq_pkg::MODE_Q32_32);
        add_request(make_double(1'b0, 1023 - 32, 52'h8_0000_0000_0000), dfq_pkg::MODE_Q32_32);
        add_request(make_double(1'b1, 1023 - 9, 52'h8_0000_0000_0000), dfq_pkg::MODE_Q56_8);
        add_request(make_double(1'b0, 1023 + 20, 52'hF_FFFF_FFFF_FFFF), dfq_pkg::MODE_Q48_16);
        add_request(make_double(1'b1, 1023 + 47, 52'h0), dfq_pkg::MODE_Q48_16);
        add_request(64'h5555_5555_5555_5555, dfq_pkg::MODE_SPARE);
        add_request(64'hAAAA_AAAA_AAAA_AAAA, dfq_pkg::MODE_Q48_16);

        repeat (1450)
            pending_requests.push_back(random_request());
        wait (pending_requests.size() == 0);
        idling_allowed = 1'b0;
        repeat (300)
            pending_requests.push_back(random_request());
        wait (pending_requests.size() == 0);
        @(negedge clk);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge clk);
        #0.1;
        $display("Checked %0d conversions across all four mode codes,", checked);
        $display("with %0d saturated results and %0d NaN inputs.", saturated_seen, nan_seen);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Timeout with %0d results still expected.", expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/dfq_pkg.sv
src/dfq_decode.sv
src/dfq_align.sv
src/double_to_fixed_quantizer.sv
dv/double_to_fixed_quantizer_test.sv
